[rtl/mfwf_pkg.sv]
// shared types and constants of the monochrome framebuffer window fill block
package mfwf_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_PIX_READ,
        ST_PIX_WRITE,
        ST_RD_ISSUE,
        ST_FINISH
    } state_t;

    // item kinds carried in tuser
    localparam logic ACT_FILL = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    localparam logic [8:0] WIDTH_RESET  = 9'd250;
    localparam logic [8:0] HEIGHT_RESET = 9'd128;

    // dimension math width, wide enough for sizes up to 1024
    localparam int DIM_W = 11;
    // pixel byte address sum, wide enough for 131072 bytes
    localparam int SUM_W = 18;
    // readable frame limit, width times band count
    localparam int LIM_W = 19;

    // eight rows per byte
    localparam int BAND_SHIFT = 3;
    localparam int ROUND_UP   = 7;
    localparam logic [2:0] ROW_IN_BAND_MAX = 3'h7;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic pix_read;
        logic pix_write;
        logic rd_issue;
        logic load_out;
        logic clear_step;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_read;
        logic empty;
        logic pix_last;
        logic out_free;
        logic clear_last;
    } dp_stat_t;

endpackage

[rtl/mono_framebuffer_window_fill.sv]
// top level of the monochrome page-packed framebuffer with window fill and refresh read
// after reset the store is swept to zero, one byte a cycle, with s_axis_tready low
// until the sweep ends; configuration writes are taken throughout
// fill: accept, dispatch, then a read and a write of the store port for each pixel of
// the window, then the output load; an empty window goes from dispatch to the output load
// refresh read: accept, dispatch, read issue, output load; one item is in work at a time
module mono_framebuffer_window_fill #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int STORE_BYTES = 8192
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // x_first[7:0], y_first[15:8], x_last[23:16], y_last[31:24],
    // paint_black[32], read_address[45:33], zero pad[47:46]
    input  logic [47:0] s_axis_tdata,
    // action[0]
    input  logic        s_axis_tuser,
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0]
    output logic [7:0]  m_axis_tdata,
    // status[0]
    output logic        m_axis_tuser
);

    mfwf_pkg::dp_cmd_t  cmd;
    mfwf_pkg::dp_stat_t stat;

    // config registers live in the datapath and are always writable
    assign cfg_ready = 1'b1;

    // sequencing: clearing sweep, per-pixel read-modify-write loop, refresh read
    mfwf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // frame store, window walk counters, range checks and the output register
    mfwf_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .STORE_BYTES (STORE_BYTES)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

[rtl/mfwf_ctrl.sv]
// controller state machine of the framebuffer window fill block
module mfwf_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mfwf_pkg::dp_stat_t stat,
    output mfwf_pkg::dp_cmd_t  cmd
);

    mfwf_pkg::state_t state_reg;
    mfwf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfwf_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            mfwf_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = mfwf_pkg::ST_IDLE;
                end
            end
            mfwf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = mfwf_pkg::ST_DISPATCH;
                end
            end
            mfwf_pkg::ST_DISPATCH:
            begin
                if (stat.is_read)
                begin
                    state_next = mfwf_pkg::ST_RD_ISSUE;
                end
                else if (stat.empty)
                begin
                    state_next = mfwf_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = mfwf_pkg::ST_PIX_READ;
                end
            end
            mfwf_pkg::ST_PIX_READ:
            begin
                cmd.pix_read = 1'b1;
                state_next   = mfwf_pkg::ST_PIX_WRITE;
            end
            mfwf_pkg::ST_PIX_WRITE:
            begin
                cmd.pix_write = 1'b1;
                state_next    = stat.pix_last ? mfwf_pkg::ST_FINISH : mfwf_pkg::ST_PIX_READ;
            end
            mfwf_pkg::ST_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = mfwf_pkg::ST_FINISH;
            end
            mfwf_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = mfwf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mfwf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/mfwf_datapath.sv]
// datapath of the framebuffer window fill block: store, counters, config, output register
module mfwf_datapath #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int STORE_BYTES = 8192
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  mfwf_pkg::dp_cmd_t                 cmd,
    output mfwf_pkg::dp_stat_t                stat,
    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_index,
    input  logic [8:0]                        cfg_data,
    input  logic [mfwf_pkg::IN_DATA_W-1:0]    in_data,
    input  logic                              in_user,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mfwf_pkg::OUT_DATA_W-1:0]   out_data,
    output logic                              out_user
);

    localparam int AW = $clog2(STORE_BYTES);

    logic [7:0] mem [STORE_BYTES];

    logic [8:0]  width_reg;
    logic [8:0]  height_reg;

    logic        action_reg;
    logic [7:0]  x_first_reg;
    logic [7:0]  y_first_reg;
    logic [7:0]  x_last_reg;
    logic [7:0]  y_last_reg;
    logic        black_reg;
    logic [12:0] raddr_reg;

    logic [7:0]  col_reg;
    logic [7:0]  row_reg;
    logic [AW-1:0] addr_reg;
    logic        ok_reg;
    logic        status_reg;
    logic [7:0]  rdata_reg;
    logic [AW-1:0] clr_reg;

    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    logic        out_status_reg;

    logic [mfwf_pkg::DIM_W-1:0] w_ext;
    logic [mfwf_pkg::DIM_W-1:0] h_round;
    logic [mfwf_pkg::DIM_W-1:0] used_w;
    logic [mfwf_pkg::DIM_W-1:0] used_h;
    logic [mfwf_pkg::SUM_W-1:0] pix_sum;
    logic                       pix_ok;
    logic [mfwf_pkg::LIM_W-1:0] rd_limit;
    logic                       rd_ok;
    logic [7:0]                 bit_mask;
    logic [AW-1:0]              rd_idx;
    logic                       mem_we;
    logic [AW-1:0]              mem_wa;
    logic [7:0]                 mem_wd;

    // effective panel size
    always_comb
    begin
        w_ext   = mfwf_pkg::DIM_W'(width_reg);
        h_round = (mfwf_pkg::DIM_W'(height_reg) + mfwf_pkg::DIM_W'(mfwf_pkg::ROUND_UP))
                  & ~mfwf_pkg::DIM_W'(mfwf_pkg::ROUND_UP);
        used_w  = (w_ext > mfwf_pkg::DIM_W'(MAX_WIDTH)) ? mfwf_pkg::DIM_W'(MAX_WIDTH) : w_ext;
        used_h  = (h_round > mfwf_pkg::DIM_W'(MAX_HEIGHT)) ? mfwf_pkg::DIM_W'(MAX_HEIGHT)
                                                           : h_round;
    end

    // pixel address and range check
    always_comb
    begin
        pix_sum  = mfwf_pkg::SUM_W'(row_reg >> mfwf_pkg::BAND_SHIFT) * mfwf_pkg::SUM_W'(used_w)
                   + mfwf_pkg::SUM_W'(col_reg);
        pix_ok   = (mfwf_pkg::DIM_W'(col_reg) < used_w)
                   && (mfwf_pkg::DIM_W'(row_reg) < used_h)
                   && (pix_sum < mfwf_pkg::SUM_W'(STORE_BYTES));
        bit_mask = 8'h80 >> (row_reg[2:0] & mfwf_pkg::ROW_IN_BAND_MAX);
    end

    // refresh read range check
    always_comb
    begin
        rd_limit = mfwf_pkg::LIM_W'(used_w)
                   * mfwf_pkg::LIM_W'(used_h >> mfwf_pkg::BAND_SHIFT);
        rd_ok    = (mfwf_pkg::LIM_W'(raddr_reg) < rd_limit)
                   && (mfwf_pkg::LIM_W'(raddr_reg) < mfwf_pkg::LIM_W'(STORE_BYTES));
        rd_idx   = cmd.rd_issue ? AW'(raddr_reg) : pix_sum[AW-1:0];
    end

    // single write port: clearing sweep or pixel update
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = black_reg ? (rdata_reg & ~bit_mask) : (rdata_reg | bit_mask);
        if (cmd.clear_step)
        begin
            mem_we = 1'b1;
            mem_wa = clr_reg;
            mem_wd = '0;
        end
        else if (cmd.pix_write && ok_reg)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.pix_read || cmd.rd_issue)
        begin
            rdata_reg <= mem[rd_idx];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mfwf_pkg::WIDTH_RESET;
            height_reg <= mfwf_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mfwf_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                mfwf_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // item fields, walk counters and per-item flags
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg  <= in_user;
            x_first_reg <= in_data[7:0];
            y_first_reg <= in_data[15:8];
            x_last_reg  <= in_data[23:16];
            y_last_reg  <= in_data[31:24];
            black_reg   <= in_data[32];
            raddr_reg   <= in_data[45:33];
            col_reg     <= in_data[7:0];
            row_reg     <= in_data[15:8];
            status_reg  <= 1'b0;
        end
        if (cmd.pix_read)
        begin
            addr_reg <= pix_sum[AW-1:0];
            ok_reg   <= pix_ok;
            if (!pix_ok)
            begin
                status_reg <= 1'b1;
            end
        end
        if (cmd.pix_write)
        begin
            if (col_reg == x_last_reg)
            begin
                col_reg <= x_first_reg;
                row_reg <= row_reg + 8'd1;
            end
            else
            begin
                col_reg <= col_reg + 8'd1;
            end
        end
        if (cmd.rd_issue)
        begin
            ok_reg     <= rd_ok;
            status_reg <= !rd_ok;
        end
    end

    // clearing sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg   <= (action_reg == mfwf_pkg::ACT_READ && ok_reg) ? ~rdata_reg : 8'h00;
            out_status_reg <= status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_status_reg;

    always_comb
    begin
        stat.is_read    = (action_reg == mfwf_pkg::ACT_READ);
        stat.empty      = (x_first_reg > x_last_reg) || (y_first_reg > y_last_reg);
        stat.pix_last   = (col_reg == x_last_reg) && (row_reg == y_last_reg);
        stat.out_free   = !out_valid_reg || out_ready;
        stat.clear_last = (clr_reg == AW'(STORE_BYTES - 1));
    end

endmodule

[rtl/mfwf_checker.sv]
// port-level checks of the framebuffer window fill block and their bind
module mfwf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser
);

    // a stalled result keeps its valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result valid dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // one item in work: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // nonzero refresh data only comes with an ok status
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata != 8'h00) |-> !m_axis_tuser)
        else $error("read data returned with error status");

    // a fresh result is only loaded while the input side is busy
    a_busy_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while the block was idle");

endmodule

bind mono_framebuffer_window_fill mfwf_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
